@@ hw/rtl/kclp_pkg.sv @@
// Package: shared types, reset values and event codes of the key click detector
`default_nettype none

package kclp_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] REG_MIN_PRESS  = 2'd1;
    localparam logic [1:0] REG_CLICK_GAP  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [15:0] MIN_PRESS_RST  = 16'd20;
    localparam logic [15:0] CLICK_GAP_RST  = 16'd300;

    // Event codes
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_LONG = 3'd4;

    // Pending click count saturates here; above the last reportable count
    localparam logic [2:0] COUNT_MAX    = 3'd4;
    localparam logic [2:0] COUNT_REPORT = 3'd3;

    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [15:0] min_press_ticks;
        logic [15:0] click_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic        pressed;
        logic        wait_release;
        logic [31:0] press_start_tick;
        logic [31:0] last_release_tick;
        logic [2:0]  click_count;
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/kclp_if.sv @@
// Interfaces: scan input channel and key event output channel
`default_nettype none

interface kclp_scan_if;
    logic        valid;
    logic        ready;
    logic        key_down;
    logic [31:0] now_tick;

    modport source (output valid, output key_down, output now_tick, input ready);
    modport sink   (input valid, input key_down, input now_tick, output ready);
endinterface

interface kclp_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_event;

    modport source (output valid, output key_event, input ready);
    modport sink   (input valid, input key_event, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/key_click_long_press_detector.sv @@
// Key click and long press detector: one scan beat in, one event beat out, every cycle
// while the event sink is ready. Each scan beat (key level plus 32-bit tick) produces
// exactly one event beat: 0 none, 1/2/3 clicks, 4 long press. A beat is taken into an
// input register, evaluated by the single-pass update logic against the key state once
// the output register is free or draining, and the event lands in that output register.
// Throughput is one beat per cycle while the sink is ready, set by the input-to-output
// register pair with ready chained back from the event sink. The user must write
// thresholds through the configuration port only while no beat is in flight; the block
// itself does not enforce it. There is no read-back.
`default_nettype none

module key_click_long_press_detector
    import kclp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    kclp_scan_if.sink        scan,
    kclp_event_if.source     events,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t        cfg;
    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  step_event;

    logic        in_vld_reg;
    logic        in_key_reg;
    logic [31:0] in_tick_reg;
    logic        out_vld_reg;
    logic [2:0]  out_event_reg;

    logic        advance;
    logic        take;

    kclp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kclp_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .key_down  (in_key_reg),
        .now_tick  (in_tick_reg),
        .nxt       (state_next),
        .key_event (step_event)
    );

    // Handshake: the held scan moves on when the output slot is free or draining
    assign advance     = in_vld_reg && (!out_vld_reg || events.ready);
    assign scan.ready  = !in_vld_reg || advance;
    assign take        = scan.valid && scan.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_key_reg  <= scan.key_down;
            in_tick_reg <= scan.now_tick;
        end
    end

    // Key state, updated once per evaluated scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (events.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= step_event;
        end
    end

    assign events.valid     = out_vld_reg;
    assign events.key_event = out_event_reg;

`ifndef SYNTHESIS
    // A long press is only latched while the key is held
    a_wait_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.wait_release |-> state_reg.pressed)
        else $error("wait_release set without a press in progress");

    // Pending clicks never pass saturation
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.click_count <= COUNT_MAX)
        else $error("click count above saturation");

    // Only defined event codes leave the block
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_event_reg <= EV_LONG)
        else $error("undefined event code on output");

    // An evaluated key-up scan always ends the press
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_key_reg |=> !state_reg.pressed && !state_reg.wait_release)
        else $error("press still open after key-up scan");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/kclp_cfg_regs.sv @@
// Configuration register file: three 16-bit threshold registers
`default_nettype none

module kclp_cfg_regs
    import kclp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything untouched
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS: cfg_next.long_press_ticks = cfg_data;
                REG_MIN_PRESS:  cfg_next.min_press_ticks  = cfg_data;
                REG_CLICK_GAP:  cfg_next.click_gap_ticks  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.min_press_ticks  <= MIN_PRESS_RST;
            cfg_reg.click_gap_ticks  <= CLICK_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/kclp_step.sv @@
// Per-scan update: next key state and the event this scan reports
`default_nettype none

module kclp_step
    import kclp_pkg::*;
(
    input  wire cfg_t         cfg,
    input  wire state_t       cur,
    input  wire logic         key_down,
    input  wire logic [31:0]  now_tick,
    output state_t            nxt,
    output logic [2:0]        key_event
);

    state_t      mid;
    logic [2:0]  press_event;
    logic [31:0] held;
    logic [31:0] gap;
    logic        held_long;
    logic        held_short;

    // Hold time of the current press, wrapping
    assign held       = now_tick - cur.press_start_tick;
    assign held_long  = held > {16'd0, cfg.long_press_ticks};
    assign held_short = held <= {16'd0, cfg.min_press_ticks};

    // Press / release tracking
    always_comb
    begin
        mid         = cur;
        press_event = EV_NONE;
        if (key_down)
        begin
            if (!cur.pressed)
            begin
                mid.press_start_tick = now_tick;
                mid.pressed          = 1'b1;
            end
            else if (!cur.wait_release && held_long)
            begin
                press_event      = EV_LONG;
                mid.wait_release = 1'b1;
            end
        end
        else if (cur.pressed)
        begin
            // Count a release only inside the click window
            if (!held_long && !held_short)
            begin
                if (cur.click_count < COUNT_MAX)
                begin
                    mid.click_count = cur.click_count + 3'd1;
                end
                mid.last_release_tick = now_tick;
            end
            mid.pressed      = 1'b0;
            mid.wait_release = 1'b0;
        end
    end

    // Quiet time since the last counted release, after this scan's update
    assign gap = now_tick - mid.last_release_tick;

    // Click report; a reportable count overrides a long press
    always_comb
    begin
        nxt       = mid;
        key_event = press_event;
        if (mid.click_count != 3'd0 && gap > {16'd0, cfg.click_gap_ticks})
        begin
            if (mid.click_count <= COUNT_REPORT)
            begin
                key_event = mid.click_count;
            end
            nxt.click_count = 3'd0;
        end
    end

endmodule

`default_nettype wire
